### hdl/sgi_pkg.sv
package sgi_pkg;

    localparam int FIELD_BITS = 16;
    localparam int OUT_BITS   = 24;

    typedef enum logic [1:0] {
        REL_CROSS    = 2'd0,
        REL_DISJOINT = 2'd1,
        REL_PARALLEL = 2'd2,
        REL_COLLINEAR = 2'd3
    } relation_t;

    typedef struct packed {
        logic      hit;
        relation_t relation;
        logic [OUT_BITS-1:0] cross_x;
        logic [OUT_BITS-1:0] cross_y;
    } result_t;

endpackage

### hdl/sgi_front.sv
module sgi_front #(
    parameter int COORD_BITS = 16,
    parameter int CB         = COORD_BITS + 2,
    parameter int PB         = 2 * COORD_BITS + 4
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic [8*sgi_pkg::FIELD_BITS-1:0] in_data,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic                          cls_hit,
    output sgi_pkg::relation_t            cls_relation,
    output logic signed [PB-1:0]          cls_tn,
    output logic signed [PB-1:0]          cls_rs,
    output logic signed [CB-1:0]          cls_px,
    output logic signed [CB-1:0]          cls_py,
    output logic signed [CB-1:0]          cls_rx,
    output logic signed [CB-1:0]          cls_ry
);
    localparam int FB = sgi_pkg::FIELD_BITS;

    logic signed [CB-1:0] c [8];
    logic s1_valid_reg, s2_valid_reg;
    logic signed [CB-1:0] px_reg, py_reg, rx_reg, ry_reg, sx_reg, sy_reg, dx_reg, dy_reg;
    logic signed [CB-1:0] ax_reg, ay_reg, qx_reg, qy_reg, bx_reg, by_reg;
    logic signed [PB-1:0] m0_reg, m1_reg, m2_reg, m3_reg, m4_reg, m5_reg;
    logic signed [CB-1:0] px2_reg, py2_reg, rx2_reg, ry2_reg;
    logic box_reg;
    logic adv1, adv2;

    always_comb
    begin
        for (int i = 0; i < 8; i++)
        begin
            logic [COORD_BITS-1:0] v;
            logic [FB-1:0] raw;
            raw = in_data[i*FB +: FB];
            v = '0;
            for (int b = 0; b < COORD_BITS && b < FB; b++)
                v[b] = raw[b];
            c[i] = CB'($signed(v));
        end
    end

    function automatic logic in_span(logic signed [CB-1:0] v, logic signed [CB-1:0] e0,
                                     logic signed [CB-1:0] e1);
        return (e0 <= v && v <= e1) || (e1 <= v && v <= e0);
    endfunction

    assign adv2     = !s2_valid_reg || out_ready;
    assign adv1     = !s1_valid_reg || adv2;
    assign in_ready = adv1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
        end
        else
        begin
            if (adv1)
                s1_valid_reg <= in_valid;
            if (adv2)
                s2_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv1 && in_valid)
        begin
            px_reg <= c[0];
            py_reg <= c[1];
            rx_reg <= c[2] - c[0];
            ry_reg <= c[3] - c[1];
            sx_reg <= c[6] - c[4];
            sy_reg <= c[7] - c[5];
            dx_reg <= c[4] - c[0];
            dy_reg <= c[5] - c[1];
            ax_reg <= c[2];
            ay_reg <= c[3];
            qx_reg <= c[4];
            qy_reg <= c[5];
            bx_reg <= c[6];
            by_reg <= c[7];
        end
        if (adv2 && s1_valid_reg)
        begin
            m0_reg  <= PB'(rx_reg) * PB'(sy_reg);
            m1_reg  <= PB'(ry_reg) * PB'(sx_reg);
            m2_reg  <= PB'(dx_reg) * PB'(sy_reg);
            m3_reg  <= PB'(dy_reg) * PB'(sx_reg);
            m4_reg  <= PB'(dx_reg) * PB'(ry_reg);
            m5_reg  <= PB'(dy_reg) * PB'(rx_reg);
            px2_reg <= px_reg;
            py2_reg <= py_reg;
            rx2_reg <= rx_reg;
            ry2_reg <= ry_reg;
            box_reg <= (in_span(qx_reg, px_reg, ax_reg) && in_span(qy_reg, py_reg, ay_reg))
                    || (in_span(bx_reg, px_reg, ax_reg) && in_span(by_reg, py_reg, ay_reg))
                    || (in_span(px_reg, qx_reg, bx_reg) && in_span(py_reg, qy_reg, by_reg));
        end
    end

    logic signed [PB-1:0] rs, tn, un;
    logic t_ok, u_ok;
    assign rs = m0_reg - m1_reg;
    assign tn = m2_reg - m3_reg;
    assign un = m4_reg - m5_reg;
    assign t_ok = (rs > 0) ? (tn >= 0 && tn <= rs) : (tn <= 0 && tn >= rs);
    assign u_ok = (rs > 0) ? (un >= 0 && un <= rs) : (un <= 0 && un >= rs);

    always_comb
    begin
        cls_hit = 1'b0;
        if (rs == 0)
        begin
            if (un == 0)
            begin
                cls_relation = sgi_pkg::REL_COLLINEAR;
                cls_hit      = box_reg;
            end
            else
                cls_relation = sgi_pkg::REL_PARALLEL;
        end
        else if (t_ok && u_ok)
        begin
            cls_relation = sgi_pkg::REL_CROSS;
            cls_hit      = 1'b1;
        end
        else
            cls_relation = sgi_pkg::REL_DISJOINT;
    end

    assign out_valid = s2_valid_reg;
    assign cls_tn = tn;
    assign cls_rs = rs;
    assign cls_px = px2_reg;
    assign cls_py = py2_reg;
    assign cls_rx = rx2_reg;
    assign cls_ry = ry2_reg;
endmodule

### hdl/sgi_back.sv
module sgi_back #(
    parameter int COORD_BITS = 16,
    parameter int FRAC_BITS  = 8,
    parameter int CB         = COORD_BITS + 2,
    parameter int PB         = 2 * COORD_BITS + 4
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  logic                 cls_hit,
    input  sgi_pkg::relation_t   cls_relation,
    input  logic signed [PB-1:0] cls_tn,
    input  logic signed [PB-1:0] cls_rs,
    input  logic signed [CB-1:0] cls_px,
    input  logic signed [CB-1:0] cls_py,
    input  logic signed [CB-1:0] cls_rx,
    input  logic signed [CB-1:0] cls_ry,
    output logic                 out_valid,
    input  logic                 out_ready,
    output sgi_pkg::result_t     out_result
);
    // Numerator magnitudes are divided by |rs| one quotient bit per stage.
    localparam int NB = PB + CB + FRAC_BITS;
    localparam int DB = PB;
    localparam int NS = NB + 1;
    localparam int OB = sgi_pkg::OUT_BITS;

    typedef struct packed {
        logic                 hit;
        sgi_pkg::relation_t   relation;
        logic                 negx;
        logic                 negy;
        logic [OB-1:0]        basex;
        logic [OB-1:0]        basey;
        logic [DB-1:0]        den;
    } side_t;

    logic          v_reg   [NS];
    side_t         sd_reg  [NS];
    logic [NB-1:0] nx_reg  [NS];
    logic [NB-1:0] ny_reg  [NS];
    logic [DB:0]   rx_rem_reg [NS];
    logic [DB:0]   ry_rem_reg [NS];
    logic          m_v_reg;
    side_t         m_sd_reg;
    logic signed [NB-1:0] m_px_reg, m_py_reg;
    logic          o_v_reg;
    sgi_pkg::result_t o_res_reg;
    logic          adv;

    assign adv       = !o_v_reg || out_ready;
    assign in_ready  = adv;
    assign out_valid = o_v_reg;
    assign out_result = o_res_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_v_reg <= 1'b0;
            o_v_reg <= 1'b0;
            for (int i = 0; i < NS; i++)
                v_reg[i] <= 1'b0;
        end
        else if (adv)
        begin
            m_v_reg  <= in_valid;
            v_reg[0] <= m_v_reg;
            for (int i = 1; i < NS; i++)
                v_reg[i] <= v_reg[i-1];
            o_v_reg  <= v_reg[NS-1];
        end
    end

    logic [DB-1:0] dmag;
    assign dmag = cls_rs[PB-1] ? DB'(-cls_rs) : DB'(cls_rs);

    side_t load_sd;
    always_comb
    begin
        load_sd      = m_sd_reg;
        load_sd.negx = m_px_reg[NB-1];
        load_sd.negy = m_py_reg[NB-1];
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            m_sd_reg.hit      <= cls_hit;
            m_sd_reg.relation <= cls_relation;
            m_sd_reg.basex    <= OB'(NB'(cls_px) << FRAC_BITS);
            m_sd_reg.basey    <= OB'(NB'(cls_py) << FRAC_BITS);
            m_sd_reg.den      <= dmag;
            m_sd_reg.negx     <= 1'b0;
            m_sd_reg.negy     <= 1'b0;
            if (cls_rs[PB-1])
            begin
                m_px_reg <= -(NB'(cls_tn) * NB'(cls_rx));
                m_py_reg <= -(NB'(cls_tn) * NB'(cls_ry));
            end
            else
            begin
                m_px_reg <= NB'(cls_tn) * NB'(cls_rx);
                m_py_reg <= NB'(cls_tn) * NB'(cls_ry);
            end

            sd_reg[0] <= load_sd;
            nx_reg[0] <= m_px_reg[NB-1] ? NB'(-m_px_reg << FRAC_BITS)
                                        : NB'(m_px_reg << FRAC_BITS);
            ny_reg[0] <= m_py_reg[NB-1] ? NB'(-m_py_reg << FRAC_BITS)
                                        : NB'(m_py_reg << FRAC_BITS);
            rx_rem_reg[0] <= '0;
            ry_rem_reg[0] <= '0;

            for (int i = 1; i < NS; i++)
            begin
                logic [DB:0] tx, ty;
                tx = {rx_rem_reg[i-1][DB-1:0], nx_reg[i-1][NB-1]};
                ty = {ry_rem_reg[i-1][DB-1:0], ny_reg[i-1][NB-1]};
                sd_reg[i] <= sd_reg[i-1];
                if (tx >= {1'b0, sd_reg[i-1].den})
                begin
                    rx_rem_reg[i] <= tx - {1'b0, sd_reg[i-1].den};
                    nx_reg[i]     <= {nx_reg[i-1][NB-2:0], 1'b1};
                end
                else
                begin
                    rx_rem_reg[i] <= tx;
                    nx_reg[i]     <= {nx_reg[i-1][NB-2:0], 1'b0};
                end
                if (ty >= {1'b0, sd_reg[i-1].den})
                begin
                    ry_rem_reg[i] <= ty - {1'b0, sd_reg[i-1].den};
                    ny_reg[i]     <= {ny_reg[i-1][NB-2:0], 1'b1};
                end
                else
                begin
                    ry_rem_reg[i] <= ty;
                    ny_reg[i]     <= {ny_reg[i-1][NB-2:0], 1'b0};
                end
            end

            o_res_reg.hit      <= sd_reg[NS-1].hit;
            o_res_reg.relation <= sd_reg[NS-1].relation;
            if (sd_reg[NS-1].relation == sgi_pkg::REL_CROSS)
            begin
                o_res_reg.cross_x <= sd_reg[NS-1].basex + (sd_reg[NS-1].negx
                    ? OB'(-nx_reg[NS-1]) : OB'(nx_reg[NS-1]));
                o_res_reg.cross_y <= sd_reg[NS-1].basey + (sd_reg[NS-1].negy
                    ? OB'(-ny_reg[NS-1]) : OB'(ny_reg[NS-1]));
            end
            else
            begin
                o_res_reg.cross_x <= '0;
                o_res_reg.cross_y <= '0;
            end
        end
    end
endmodule

### hdl/sgi_queue.sv
module sgi_queue #(
    parameter int W = 8
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         in_valid,
    output logic         in_ready,
    input  logic [W-1:0] in_data,
    output logic         out_valid,
    input  logic         out_ready,
    output logic [W-1:0] out_data
);
    logic [W-1:0] mem_reg [2];
    logic [1:0] cnt_reg;
    logic wp_reg, rp_reg;
    logic push, pop;

    assign in_ready  = cnt_reg != 2'd2;
    assign out_valid = cnt_reg != 2'd0;
    assign out_data  = mem_reg[rp_reg];
    assign push = in_valid && in_ready;
    assign pop  = out_valid && out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
            wp_reg  <= 1'b0;
            rp_reg  <= 1'b0;
        end
        else
        begin
            cnt_reg <= cnt_reg + 2'(push) - 2'(pop);
            if (push)
                wp_reg <= !wp_reg;
            if (pop)
                rp_reg <= !rp_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wp_reg] <= in_data;
    end
endmodule

### hdl/segment_intersection_unit.sv
// Segment intersection unit. Each slave beat carries two segments, a from
// (a_start) to (a_end) and b from (b_start) to (b_end); each master beat carries
// the hit flag, the relation code and the crossing point in fixed point with
// FRAC_BITS fraction bits, zero unless the segments cross at a single point.
// One beat is accepted per cycle while the master side takes results.
// The front end registers the differences, then the products, and forms the
// three cross products and classifies the pair; a two-entry queue follows; the
// back end multiplies into a register and divides with a restoring pipeline of
// one quotient bit per stage, 3*COORD_BITS+FRAC_BITS+7 stages, plus an output
// register. Reset clears all valid flags; no beat is lost or repeated. When the
// receiver stalls, the back end holds, the queue fills, and then tready falls.
module segment_intersection_unit #(
    parameter int COORD_BITS = 16,
    parameter int FRAC_BITS  = 8
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // a_start_x, a_start_y, a_end_x, a_end_y, b_start_x, b_start_y, b_end_x, b_end_y
    input  logic [127:0] s_axis_tdata,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // hit, relation, cross_x, cross_y, five zero bits
    output logic [55:0]  m_axis_tdata
);
    localparam int CB = COORD_BITS + 2;
    localparam int PB = 2 * COORD_BITS + 4;
    localparam int QW = 3 + 4 * CB + 2 * PB;

    logic f_valid, f_ready, q_valid, q_ready, f_hit;
    sgi_pkg::relation_t f_rel;
    logic signed [PB-1:0] f_tn, f_rs;
    logic signed [CB-1:0] f_px, f_py, f_rx, f_ry;
    logic [QW-1:0] q_in, q_out;
    sgi_pkg::result_t res;

    sgi_front #(.COORD_BITS(COORD_BITS), .CB(CB), .PB(PB)) u_front (
        .clk, .rst_n, .in_valid(s_axis_tvalid), .in_ready(s_axis_tready),
        .in_data(s_axis_tdata), .out_valid(f_valid), .out_ready(f_ready),
        .cls_hit(f_hit), .cls_relation(f_rel), .cls_tn(f_tn), .cls_rs(f_rs),
        .cls_px(f_px), .cls_py(f_py), .cls_rx(f_rx), .cls_ry(f_ry)
    );

    assign q_in = {f_hit, f_rel, f_tn, f_rs, f_px, f_py, f_rx, f_ry};

    sgi_queue #(.W(QW)) u_queue (
        .clk, .rst_n, .in_valid(f_valid), .in_ready(f_ready), .in_data(q_in),
        .out_valid(q_valid), .out_ready(q_ready), .out_data(q_out)
    );

    sgi_back #(.COORD_BITS(COORD_BITS), .FRAC_BITS(FRAC_BITS), .CB(CB), .PB(PB)) u_back (
        .clk, .rst_n, .in_valid(q_valid), .in_ready(q_ready),
        .cls_hit(q_out[QW-1]),
        .cls_relation(sgi_pkg::relation_t'(q_out[QW-2 -: 2])),
        .cls_tn(q_out[4*CB+2*PB-1 -: PB]), .cls_rs(q_out[4*CB+PB-1 -: PB]),
        .cls_px(q_out[4*CB-1 -: CB]), .cls_py(q_out[3*CB-1 -: CB]),
        .cls_rx(q_out[2*CB-1 -: CB]), .cls_ry(q_out[CB-1:0]),
        .out_valid(m_axis_tvalid), .out_ready(m_axis_tready), .out_result(res)
    );

    assign m_axis_tdata = {5'd0, res.cross_y, res.cross_x, res.relation, res.hit};
endmodule

### hdl/sgi_checker.sv
module sgi_checker (
    input logic         clk,
    input logic         rst_n,
    input logic         m_axis_tvalid,
    input logic         m_axis_tready,
    input logic [55:0]  m_axis_tdata
);
    a_cross_hits: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tdata[2:1] == sgi_pkg::REL_CROSS |-> m_axis_tdata[0])
        else $error("crossing without hit");
    a_miss: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && (m_axis_tdata[2:1] == sgi_pkg::REL_DISJOINT ||
        m_axis_tdata[2:1] == sgi_pkg::REL_PARALLEL) |-> !m_axis_tdata[0])
        else $error("hit on disjoint pair");
    a_zero_point: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tdata[2:1] != sgi_pkg::REL_CROSS
        |-> m_axis_tdata[50:3] == '0)
        else $error("point set without crossing");
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("stalled beat changed");
endmodule

bind segment_intersection_unit sgi_checker u_sgi_checker (
    .clk, .rst_n, .m_axis_tvalid, .m_axis_tready, .m_axis_tdata
);

### tb/sv/segment_intersection_unit_tb.sv
module segment_intersection_unit_tb;

    localparam int FRAC = 8;
    localparam int IDLE_LIMIT = 20000;
    localparam int DRAIN_CYCLES = 200;

    typedef struct packed {
        logic [15:0] by1;
        logic [15:0] bx1;
        logic [15:0] qy;
        logic [15:0] qx;
        logic [15:0] ay1;
        logic [15:0] ax1;
        logic [15:0] py;
        logic [15:0] px;
    } pair_t;

    typedef struct {
        logic      hit;
        sgi_pkg::relation_t relation;
        logic [23:0] cross_x;
        logic [23:0] cross_y;
    } verdict_t;

    class intersection_board;
        verdict_t pending[$];
        int errors = 0;

        function automatic logic [23:0] fixed_point(longint start, longint num, longint den);
            longint off;
            off = (num * (64'sd1 <<< FRAC)) / den;
            return 24'(start * (64'sd1 <<< FRAC) + off);
        endfunction

        function automatic bit in_span(longint v, longint e0, longint e1);
            return (e0 <= v && v <= e1) || (e1 <= v && v <= e0);
        endfunction

        function automatic bit ratio_ok(longint num, longint den);
            if (den > 0)
                return num >= 0 && num <= den;
            return num <= 0 && num >= den;
        endfunction

        function void note_pair(pair_t p);
            longint px, py, ax, ay, qx, qy, bx, by, rx, ry, sx, sy, dx, dy, rs, tn, un;
            verdict_t v;
            px = longint'($signed(p.px));
            py = longint'($signed(p.py));
            ax = longint'($signed(p.ax1));
            ay = longint'($signed(p.ay1));
            qx = longint'($signed(p.qx));
            qy = longint'($signed(p.qy));
            bx = longint'($signed(p.bx1));
            by = longint'($signed(p.by1));
            rx = ax - px;
            ry = ay - py;
            sx = bx - qx;
            sy = by - qy;
            dx = qx - px;
            dy = qy - py;
            rs = rx * sy - ry * sx;
            tn = dx * sy - dy * sx;
            un = dx * ry - dy * rx;
            v.hit = 1'b0;
            v.cross_x = '0;
            v.cross_y = '0;
            if (rs == 0)
            begin
                if (un == 0)
                begin
                    v.relation = sgi_pkg::REL_COLLINEAR;
                    v.hit = (in_span(qx, px, ax) && in_span(qy, py, ay))
                         || (in_span(bx, px, ax) && in_span(by, py, ay))
                         || (in_span(px, qx, bx) && in_span(py, qy, by));
                end
                else
                    v.relation = sgi_pkg::REL_PARALLEL;
            end
            else if (ratio_ok(tn, rs) && ratio_ok(un, rs))
            begin
                v.relation = sgi_pkg::REL_CROSS;
                v.hit = 1'b1;
                v.cross_x = fixed_point(px, tn * rx, rs);
                v.cross_y = fixed_point(py, tn * ry, rs);
            end
            else
                v.relation = sgi_pkg::REL_DISJOINT;
            pending.push_back(v);
        endfunction

        function void check_result(logic [55:0] d);
            verdict_t e;
            if (pending.size() == 0)
            begin
                $error("result beat with nothing expected: %h", d);
                errors++;
                return;
            end
            e = pending.pop_front();
            if (d[0] !== e.hit)
            begin
                $error("hit: expected %0d, actual %0d", e.hit, d[0]);
                errors++;
            end
            if (d[2:1] !== e.relation)
            begin
                $error("relation: expected %0d, actual %0d", e.relation, d[2:1]);
                errors++;
            end
            if (d[26:3] !== e.cross_x)
            begin
                $error("cross_x: expected %h, actual %h", e.cross_x, d[26:3]);
                errors++;
            end
            if (d[50:27] !== e.cross_y)
            begin
                $error("cross_y: expected %h, actual %h", e.cross_y, d[50:27]);
                errors++;
            end
            if (d[55:51] !== 5'd0)
            begin
                $error("padding: expected 0, actual %h", d[55:51]);
                errors++;
            end
        endfunction
    endclass

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic s_axis_tvalid = 1'b0;
    logic s_axis_tready;
    logic [127:0] s_axis_tdata = '0;
    logic m_axis_tvalid;
    logic m_axis_tready = 1'b0;
    logic [55:0] m_axis_tdata;

    intersection_board board = new();
    bit hold_off = 1'b0;
    bit sending_done = 1'b0;
    int idle_cycles = 0;
    int accepted_pairs = 0;

    segment_intersection_unit dut (
        .clk(clk),
        .rst_n(rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata)
    );

    always #10 clk = ~clk;

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (s_axis_tvalid && s_axis_tready)
            begin
                board.note_pair(pair_t'(s_axis_tdata));
                accepted_pairs++;
            end
            if (m_axis_tvalid && m_axis_tready)
                board.check_result(m_axis_tdata);
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
        end
    end

    always @(posedge clk)
    begin
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    // Receiver: stalls in a shifting pattern, with calm stretches and one long hold-off.
    initial
    begin
        int mode;
        int n;
        while (!rst_n)
            @(posedge clk);
        forever
        begin
            mode = $urandom_range(0, 3);
            n = $urandom_range(10, 80);
            repeat (n)
            begin
                @(posedge clk);
                if (hold_off)
                    m_axis_tready <= 1'b0;
                else
                    case (mode)
                        0: m_axis_tready <= 1'b1;
                        1: m_axis_tready <= ($urandom_range(0, 3) != 0);
                        2: m_axis_tready <= ($urandom_range(0, 3) == 0);
                        default: m_axis_tready <= ($urandom_range(0, 1) == 1);
                    endcase
            end
        end
    end

    initial
    begin
        @(posedge clk);
        wait (accepted_pairs > 300);
        hold_off = 1'b1;
        repeat (400)
            @(posedge clk);
        hold_off = 1'b0;
    end

    function automatic logic [15:0] pick_coord(int style);
        case (style)
            0: return 16'($urandom);
            1: return 16'($signed($urandom_range(0, 40)) - 20);
            2: return $urandom_range(0, 1) ? 16'h7fff : 16'h8000;
            default: return 16'($signed($urandom_range(0, 2000)) - 1000);
        endcase
    endfunction

    task automatic send_pair(pair_t p);
        @(posedge clk);
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= p;
        do
            @(posedge clk);
        while (!s_axis_tready);
        s_axis_tvalid <= 1'b0;
    endtask

    // Keeps tvalid high between beats of one burst.
    task automatic send_burst(pair_t ps[$]);
        foreach (ps[i])
        begin
            s_axis_tvalid <= 1'b1;
            s_axis_tdata <= ps[i];
            @(posedge clk);
            while (!s_axis_tready)
                @(posedge clk);
        end
        s_axis_tvalid <= 1'b0;
    endtask

    function automatic pair_t random_pair();
        pair_t p;
        int style;
        int shape;
        style = $urandom_range(0, 3);
        p = {pick_coord(style), pick_coord(style), pick_coord(style), pick_coord(style),
             pick_coord(style), pick_coord(style), pick_coord(style), pick_coord(style)};
        shape = $urandom_range(0, 9);
        if (shape == 0)
        begin
            // b identical to a
            p.qx = p.px;
            p.qy = p.py;
            p.bx1 = p.ax1;
            p.by1 = p.ay1;
        end
        else if (shape == 1)
        begin
            p.bx1 = p.qx + (p.ax1 - p.px);
            p.by1 = p.qy + (p.ay1 - p.py);
        end
        return p;
    endfunction

    initial
    begin
        pair_t d[$];
        pair_t ps[$];
        pair_t p;
        int len;
        bit drained;
        drained = 1'b0;
        repeat (10)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        d.push_back({16'd10, 16'd0, 16'd0, 16'd10, 16'd10, 16'd10, 16'd0, 16'd0});
        d.push_back({16'd3, 16'd20, 16'd0, 16'd20, 16'd1, 16'd1, 16'd0, 16'd0});
        d.push_back({16'd5, 16'd10, 16'd5, 16'd0, 16'd0, 16'd10, 16'd0, 16'd0});
        d.push_back({16'd0, 16'd15, 16'd0, 16'd5, 16'd0, 16'd10, 16'd0, 16'd0});
        d.push_back({16'd0, 16'd25, 16'd0, 16'd15, 16'd0, 16'd10, 16'd0, 16'd0});
        d.push_back({16'd0, 16'd8, 16'd0, 16'd2, 16'd0, 16'd10, 16'd0, 16'd0});
        d.push_back({16'd0, 16'd20, 16'd0, 16'd0, 16'd0, 16'd5, 16'd0, 16'd2});
        d.push_back({16'd4, 16'd4, 16'd4, 16'd4, 16'd4, 16'd4, 16'd4, 16'd4});
        d.push_back({16'd5, 16'd5, 16'd5, 16'd5, 16'd4, 16'd4, 16'd4, 16'd4});
        d.push_back({16'd7, 16'd3, 16'd7, 16'd3, 16'd9, 16'd9, 16'd1, 16'd1});
        d.push_back({16'h8000, 16'h7fff, 16'h7fff, 16'h8000, 16'h7fff, 16'h7fff,
                     16'h8000, 16'h8000});
        d.push_back({16'hffff, 16'hffff, 16'h8000, 16'h8000, 16'h7fff, 16'h8000,
                     16'h8000, 16'h7fff});
        d.push_back({16'd7, 16'd3, 16'hfffd, 16'hfffb, 16'd0, 16'd11, 16'd0, 16'hffff});
        d.push_back({16'd1, 16'd2, 16'd1, 16'd0, 16'd3, 16'd0, 16'd0, 16'd0});
        d.push_back({16'd0, 16'd10, 16'd5, 16'd10, 16'd10, 16'd0, 16'd0, 16'd0});
        foreach (d[i])
            send_pair(d[i]);

        while (accepted_pairs < 850)
        begin
            if (!drained && accepted_pairs > 500)
            begin
                wait (board.pending.size() == 0);
                @(posedge clk);
                drained = 1'b1;
            end
            ps.delete();
            len = $urandom_range(1, 40);
            repeat (len)
            begin
                p = random_pair();
                ps.push_back(p);
            end
            @(posedge clk);
            send_burst(ps);
            if ($urandom_range(0, 2) != 0)
                repeat ($urandom_range(1, 30))
                    @(posedge clk);
        end

        while (board.pending.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES)
            @(posedge clk);
        if (board.errors == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
